/* rtl/core/transport_stream_video_demux_core_defines.svh */
// assertion macros shared by the demux core modules
`ifndef TRANSPORT_STREAM_VIDEO_DEMUX_CORE_DEFINES_SVH
`define TRANSPORT_STREAM_VIDEO_DEMUX_CORE_DEFINES_SVH

// same-cycle implication, checked outside reset
`define TSVD_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked outside reset
`define TSVD_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/core/tsvd_pkg.sv */
// shared types and constants of the transport stream video demux
package tsvd_pkg;

  // longest packet, sets the sync history depth
  localparam int MAX_PACKET_BYTES = 204;
  localparam logic [7:0] SEEN_MAX = 8'(MAX_PACKET_BYTES + 1);

  localparam logic [7:0] SYNC_CODE = 8'h47;
  localparam logic [7:0] PES_PREFIX_SKIP = 8'd7;
  localparam logic [7:0] PREFIX_BYTES = 8'd4;
  localparam logic [7:0] PARITY_BYTES = 8'd16;

  // packet lengths and the count loaded at sync (length minus one)
  localparam logic [7:0] LEN_188 = 8'd188;
  localparam logic [7:0] LEN_192 = 8'd192;
  localparam logic [7:0] LEN_204 = 8'd204;
  localparam logic [7:0] REM_188 = 8'd187;
  localparam logic [7:0] REM_204 = 8'd203;

  // packet format codes
  localparam logic [1:0] FMT_188 = 2'd0;
  localparam logic [1:0] FMT_192 = 2'd1;
  localparam logic [1:0] FMT_204 = 2'd2;

  // configuration register indexes
  localparam logic CFG_PACKET_FORMAT = 1'b0;
  localparam logic CFG_VIDEO_PID = 1'b1;

  localparam int PID_W = 13;

  // queue between parser and output stage
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [3:0] {
    PH_PREFIX    = 4'd0,
    PH_HUNT      = 4'd1,
    PH_HDR1      = 4'd2,
    PH_HDR2      = 4'd3,
    PH_HDR3      = 4'd4,
    PH_AF_LEN    = 4'd5,
    PH_AF_SKIP   = 4'd6,
    PH_PES_SKIP  = 4'd7,
    PH_PES_CODE  = 4'd8,
    PH_PES_HLEN  = 4'd9,
    PH_PES_HSKIP = 4'd10,
    PH_PAYLOAD   = 4'd11,
    PH_DROP      = 4'd12
  } tsvd_phase_t;

  // one payload word
  typedef struct packed {
    logic [7:0] payload_byte;
    logic       unit_start;
    logic       packet_last;
  } tsvd_word_t;

  // queue status seen by both sides
  typedef struct packed {
    logic full;
    logic empty;
  } tsvd_qstat_t;

endpackage

/* rtl/core/tsvd_front.sv */
// byte parser: sync hunt, header decode, skips and payload selection
module tsvd_front import tsvd_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic [7:0]       in_byte,
  input  logic             cfg_valid,
  input  logic             cfg_index,
  input  logic [PID_W-1:0] cfg_data,
  input  tsvd_qstat_t      qstat,
  output logic             push,
  output tsvd_word_t       push_word
);

  tsvd_phase_t           phase_r, phase_nxt;
  logic [7:0]            br_r, br_nxt;
  logic [7:0]            skip_r, skip_nxt;
  logic [15:0]           hh_r, hh_nxt;
  logic [7:0]            seen_r;
  logic [MAX_PACKET_BYTES-1:0] hist_r;
  logic [1:0]            fmt_r;
  logic [PID_W-1:0]      pid_r;

  logic       acc;
  logic [7:0] br_dec;
  logic [7:0] skip_dec;
  logic [7:0] pkt_len;
  logic [7:0] par_len;
  logic       hist_tap;
  logic       sync_ok;
  logic       hunt_hit;
  logic       sel_pid;
  logic [1:0] afc;

  assign in_stall = qstat.full;
  assign acc      = in_valid && !in_stall;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fmt_r <= FMT_188;
      pid_r <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_PACKET_FORMAT: fmt_r <= cfg_data[1:0];
        CFG_VIDEO_PID:     pid_r <= cfg_data;
        default:           ;
      endcase
    end
  end

  // packet length, parity length and history tap for the current format
  always_comb begin
    unique case (fmt_r)
      FMT_192: begin
        pkt_len  = LEN_192;
        par_len  = '0;
        hist_tap = hist_r[int'(LEN_192) - 1];
      end
      FMT_204: begin
        pkt_len  = LEN_204;
        par_len  = PARITY_BYTES;
        hist_tap = hist_r[int'(LEN_204) - 1];
      end
      default: begin
        pkt_len  = LEN_188;
        par_len  = '0;
        hist_tap = hist_r[int'(LEN_188) - 1];
      end
    endcase
  end

  // a sync byte counts early in the stream or when one packet back was a sync
  assign sync_ok  = (seen_r < pkt_len) || hist_tap;
  assign hunt_hit = (in_byte == SYNC_CODE) && sync_ok;
  assign br_dec   = (br_r != 8'd0) ? br_r - 8'd1 : br_r;
  assign skip_dec = (skip_r != 8'd0) ? skip_r - 8'd1 : skip_r;
  assign sel_pid  = (hh_r[PID_W-1:0] == pid_r) && (br_dec != 8'd0);
  assign afc      = in_byte[5:4];

  // parser state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_PREFIX;
      br_r    <= '0;
      skip_r  <= '0;
      hh_r    <= '0;
    end else begin
      phase_r <= phase_nxt;
      br_r    <= br_nxt;
      skip_r  <= skip_nxt;
      hh_r    <= hh_nxt;
    end
  end

  // stream history for sync confirmation
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hist_r <= '0;
      seen_r <= '0;
    end else if (acc) begin
      hist_r <= {hist_r[MAX_PACKET_BYTES-2:0], in_byte == SYNC_CODE};
      if (seen_r < SEEN_MAX) begin
        seen_r <= seen_r + 8'd1;
      end
    end
  end

  // next phase and emitted word
  always_comb begin
    phase_nxt = phase_r;
    br_nxt    = br_r;
    skip_nxt  = skip_r;
    hh_nxt    = hh_r;
    push      = 1'b0;
    push_word.payload_byte = in_byte;
    push_word.unit_start   = hh_r[14];
    push_word.packet_last  = (br_dec == par_len);
    if (acc) begin
      if (phase_r != PH_PREFIX && phase_r != PH_HUNT) begin
        br_nxt = br_dec;
      end
      unique case (phase_r)
        PH_PREFIX: begin
          if (fmt_r == FMT_192 && skip_r < PREFIX_BYTES) begin
            skip_nxt = skip_r + 8'd1;
            if (skip_r + 8'd1 >= PREFIX_BYTES) begin
              phase_nxt = PH_HUNT;
            end
          end else begin
            phase_nxt = PH_HUNT;
            if (hunt_hit) begin
              br_nxt    = (fmt_r == FMT_204) ? REM_204 : REM_188;
              hh_nxt    = '0;
              phase_nxt = PH_HDR1;
            end
          end
        end
        PH_HUNT: begin
          if (hunt_hit) begin
            br_nxt    = (fmt_r == FMT_204) ? REM_204 : REM_188;
            hh_nxt    = '0;
            phase_nxt = PH_HDR1;
          end
        end
        PH_HDR1: begin
          hh_nxt    = {in_byte, 8'h00};
          phase_nxt = PH_HDR2;
        end
        PH_HDR2: begin
          hh_nxt    = {hh_r[15:8], in_byte};
          phase_nxt = PH_HDR3;
        end
        PH_HDR3: begin
          if (hh_r[15] || afc == 2'd0) begin
            phase_nxt = PH_DROP;
          end else if (afc[1]) begin
            phase_nxt = PH_AF_LEN;
          end else if (!sel_pid) begin
            phase_nxt = PH_DROP;
          end else if (hh_r[14]) begin
            skip_nxt  = PES_PREFIX_SKIP;
            phase_nxt = PH_PES_SKIP;
          end else begin
            phase_nxt = PH_PAYLOAD;
          end
        end
        PH_AF_LEN: begin
          if (in_byte != 8'd0) begin
            skip_nxt  = in_byte;
            phase_nxt = PH_AF_SKIP;
          end else if (!sel_pid) begin
            phase_nxt = PH_DROP;
          end else if (hh_r[14]) begin
            skip_nxt  = PES_PREFIX_SKIP;
            phase_nxt = PH_PES_SKIP;
          end else begin
            phase_nxt = PH_PAYLOAD;
          end
        end
        PH_AF_SKIP: begin
          skip_nxt = skip_dec;
          if (skip_dec == 8'd0) begin
            if (!sel_pid) begin
              phase_nxt = PH_DROP;
            end else if (hh_r[14]) begin
              skip_nxt  = PES_PREFIX_SKIP;
              phase_nxt = PH_PES_SKIP;
            end else begin
              phase_nxt = PH_PAYLOAD;
            end
          end
        end
        PH_PES_SKIP: begin
          skip_nxt = skip_dec;
          if (skip_dec == 8'd0) begin
            phase_nxt = PH_PES_CODE;
          end
        end
        PH_PES_CODE: begin
          phase_nxt = PH_PES_HLEN;
        end
        PH_PES_HLEN: begin
          if (in_byte == 8'd0) begin
            phase_nxt = PH_PAYLOAD;
          end else begin
            skip_nxt  = in_byte;
            phase_nxt = PH_PES_HSKIP;
          end
        end
        PH_PES_HSKIP: begin
          skip_nxt = skip_dec;
          if (skip_dec == 8'd0) begin
            phase_nxt = PH_PAYLOAD;
          end
        end
        PH_PAYLOAD: begin
          // parity tail of 204-byte packets is counted but not emitted
          if (br_dec >= par_len) begin
            push       = 1'b1;
            hh_nxt[14] = 1'b0;
          end
        end
        default: ;
      endcase
      // packet end returns to the prefix phase
      if (phase_r != PH_PREFIX && phase_r != PH_HUNT && br_dec == 8'd0) begin
        phase_nxt = PH_PREFIX;
        skip_nxt  = '0;
      end
    end
  end

`include "transport_stream_video_demux_core_defines.svh"

  `TSVD_ASSERT_IMP(a_push_in_payload, push, phase_r == PH_PAYLOAD && acc, "word pushed outside payload phase")
  `TSVD_ASSERT_IMP(a_count_bound, 1'b1, br_r <= REM_204, "packet byte count out of range")

endmodule

/* rtl/core/tsvd_queue.sv */
// short word queue between the parser and the output stage
module tsvd_queue import tsvd_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push,
  input  tsvd_word_t  push_word,
  input  logic        pop,
  output tsvd_word_t  head_word,
  output tsvd_qstat_t qstat
);

  tsvd_word_t        mem_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r;
  logic [QPTR_W-1:0] rd_ptr_r;
  logic [QCNT_W-1:0] count_r;

  assign qstat.full  = (count_r == QCNT_W'(QUEUE_DEPTH));
  assign qstat.empty = (count_r == '0);
  assign head_word   = mem_r[rd_ptr_r];

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_word;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= QPTR_W'(wr_ptr_r + 1'b1);
      end
      if (pop) begin
        rd_ptr_r <= QPTR_W'(rd_ptr_r + 1'b1);
      end
      case ({push, pop})
        2'b10:   count_r <= count_r + 1'b1;
        2'b01:   count_r <= count_r - 1'b1;
        default: ;
      endcase
    end
  end

`include "transport_stream_video_demux_core_defines.svh"

  `TSVD_ASSERT_IMP(a_no_push_full, push, !qstat.full, "push into full queue")
  `TSVD_ASSERT_IMP(a_no_pop_empty, pop, !qstat.empty, "pop from empty queue")
  `TSVD_ASSERT_NXT(a_count_up, push && !pop, count_r == QCNT_W'($past(count_r) + 1'b1), "queue count did not grow")

endmodule

/* rtl/core/tsvd_back.sv */
// output register fed from the queue
module tsvd_back import tsvd_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  tsvd_qstat_t qstat,
  input  tsvd_word_t  head_word,
  output logic        pop,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_payload_byte,
  output logic        out_unit_start,
  output logic        out_packet_last
);

  logic       out_valid_r;
  tsvd_word_t out_word_r;
  logic       load;

  // refill when empty or when the held word is taken
  assign load = !out_valid_r || !out_stall;
  assign pop  = load && !qstat.empty;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load) begin
      out_valid_r <= !qstat.empty;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      out_word_r <= head_word;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_payload_byte = out_word_r.payload_byte;
  assign out_unit_start   = out_word_r.unit_start;
  assign out_packet_last  = out_word_r.packet_last;

endmodule

/* rtl/core/transport_stream_video_demux_core.sv */
// Transport stream video demux: takes one stream byte per cycle while the
// queue has room; the parser handles each byte in the cycle it is accepted,
// so the sustained rate is one byte per clock unless the output stalls.
// Payload words of the selected PID leave through a four-word queue and an
// output register; the input stalls only while that queue is full.
// Configuration writes are always ready and take effect on the next byte.
module transport_stream_video_demux_core import tsvd_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic [7:0]       in_byte,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [7:0]       out_payload_byte,
  output logic             out_unit_start,
  output logic             out_packet_last,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic             cfg_index,
  input  logic [PID_W-1:0] cfg_data
);

  tsvd_qstat_t qstat;
  tsvd_word_t  push_word;
  tsvd_word_t  head_word;
  logic        push;
  logic        pop;

  assign cfg_ready = 1'b1;

  // parser
  tsvd_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_byte   (in_byte),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .qstat     (qstat),
    .push      (push),
    .push_word (push_word)
  );

  // word queue
  tsvd_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_word (push_word),
    .pop       (pop),
    .head_word (head_word),
    .qstat     (qstat)
  );

  // output stage
  tsvd_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .qstat            (qstat),
    .head_word        (head_word),
    .pop              (pop),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_payload_byte (out_payload_byte),
    .out_unit_start   (out_unit_start),
    .out_packet_last  (out_packet_last)
  );

endmodule
